>>> src/tlik_pkg.sv
// Shared types and constants for the two-link arm inverse kinematics block.
package tlik_pkg;

	localparam int GuardShift = 24;
	localparam int TableLen = 24;

	// Register indexes of the configuration port
	typedef enum logic [1:0] {
		REG_LINK_LENGTH   = 2'd0,
		REG_BASE_HEIGHT   = 2'd1,
		REG_GRIPPER_PITCH = 2'd2
	} reg_index_t;

	// atan(2^-i) in degrees scaled by 2^16
	function automatic logic [21:0] atan_deg16(input logic [4:0] i);
		logic [21:0] r;
		begin
			unique case (i)
				5'd0: r = 22'd2949120;
				5'd1: r = 22'd1740967;
				5'd2: r = 22'd919879;
				5'd3: r = 22'd466945;
				5'd4: r = 22'd234379;
				5'd5: r = 22'd117304;
				5'd6: r = 22'd58666;
				5'd7: r = 22'd29335;
				5'd8: r = 22'd14668;
				5'd9: r = 22'd7334;
				5'd10: r = 22'd3667;
				5'd11: r = 22'd1833;
				5'd12: r = 22'd917;
				5'd13: r = 22'd458;
				5'd14: r = 22'd229;
				5'd15: r = 22'd115;
				5'd16: r = 22'd57;
				5'd17: r = 22'd29;
				5'd18: r = 22'd14;
				5'd19: r = 22'd7;
				5'd20: r = 22'd4;
				5'd21: r = 22'd2;
				5'd22: r = 22'd1;
				default: r = 22'd0;
			endcase
			return r;
		end
	endfunction

endpackage

>>> src/tlik_if.sv
// Valid/ready channel interfaces for targets, angles and configuration writes.
interface tlik_target_if;
	logic valid;
	logic ready;
	logic signed [15:0] target_x;
	logic signed [15:0] target_y;
	modport source (output valid, target_x, target_y, input ready);
	modport sink (input valid, target_x, target_y, output ready);
endinterface

interface tlik_angle_if;
	logic valid;
	logic ready;
	logic [7:0] shoulder_angle;
	logic [7:0] elbow_angle;
	logic [7:0] wrist_angle;
	modport source (output valid, shoulder_angle, elbow_angle, wrist_angle, input ready);
	modport sink (input valid, shoulder_angle, elbow_angle, wrist_angle, output ready);
endinterface

interface tlik_cfg_if;
	logic valid;
	logic ready;
	logic [1:0] index;
	logic [15:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> src/tlik_sqrt_cell.sv
// One restoring square-root cell: settles one result bit per cycle while en is high.
module tlik_sqrt_cell #(
	parameter int RadW = 36,
	parameter int ResW = 18,
	parameter int Step = 0
) (
	input  logic            clk,
	input  logic            en,
	input  logic [RadW-1:0] rem_in,
	input  logic [ResW-1:0] root_in,
	output logic [RadW-1:0] rem_out,
	output logic [ResW-1:0] root_out
);
	localparam int Pos = ResW - 1 - Step;
	logic [RadW:0] trial;
	logic [RadW:0] cand;

	// trial value is (2*root + 2^pos) * 2^pos
	always_comb begin
		cand = ((RadW+1)'(root_in) << (Pos + 1)) | ((RadW+1)'(1) << (2 * Pos));
		trial = {1'b0, rem_in} - cand;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (!trial[RadW]) begin
				rem_out <= trial[RadW-1:0];
				root_out <= root_in | (ResW'(1) << Pos);
			end else begin
				rem_out <= rem_in;
				root_out <= root_in;
			end
		end
	end
endmodule

>>> src/tlik_cordic_cell.sv
// One CORDIC vectoring cell: a micro-rotation by atan(2^-i) toward y = 0.
module tlik_cordic_cell
	import tlik_pkg::*;
#(
	parameter int Stage = 0,
	parameter int FracBits = 8,
	parameter int W = 44,
	parameter int ZW = 20
) (
	input  logic                clk,
	input  logic                en,
	input  logic signed [W-1:0] x_in,
	input  logic signed [W-1:0] y_in,
	input  logic signed [ZW-1:0] z_in,
	output logic signed [W-1:0] x_out,
	output logic signed [W-1:0] y_out,
	output logic signed [ZW-1:0] z_out
);
	localparam logic [21:0] Raw = atan_deg16(5'(Stage));
	localparam logic [22:0] Rnd = 23'(Raw) + (23'(1) << (15 - FracBits));
	localparam logic signed [ZW-1:0] Ang = ZW'(Rnd >> (16 - FracBits));

	always_ff @(posedge clk) begin
		if (en) begin
			if (!y_in[W-1]) begin
				x_out <= x_in + (y_in >>> Stage);
				y_out <= y_in - (x_in >>> Stage);
				z_out <= z_in + Ang;
			end else begin
				x_out <= x_in - (y_in >>> Stage);
				y_out <= y_in + (x_in >>> Stage);
				z_out <= z_in - Ang;
			end
		end
	end
endmodule

>>> src/tlik_cordic.sv
// Pipelined CORDIC atan2 in degrees: pre-rotation followed by a chain of cells.
module tlik_cordic
	import tlik_pkg::*;
#(
	parameter int Stages = 16,
	parameter int FracBits = 8,
	parameter int InW = 18,
	parameter int W = 44,
	parameter int ZW = 20
) (
	input  logic                  clk,
	input  logic                  en,
	input  logic signed [InW-1:0] y,
	input  logic signed [InW-1:0] x,
	output logic signed [ZW-1:0]  z
);
	localparam int N = (Stages > TableLen) ? TableLen : Stages;

	logic signed [W-1:0] xc [0:N];
	logic signed [W-1:0] yc [0:N];
	logic signed [ZW-1:0] zc [0:N];
	logic zero_c [0:N];
	logic signed [W-1:0] xs, ys;

	// scale and pre-rotate into the right half plane
	always_comb begin
		xs = W'(x) <<< GuardShift;
		ys = W'(y) <<< GuardShift;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_c[0] <= (x == '0) && (y == '0);
			if (xs[W-1]) begin
				if (!ys[W-1]) begin
					xc[0] <= ys; yc[0] <= -xs; zc[0] <= ZW'(90 <<< FracBits);
				end else begin
					xc[0] <= -ys; yc[0] <= xs; zc[0] <= -ZW'(90 <<< FracBits);
				end
			end else begin
				xc[0] <= xs; yc[0] <= ys; zc[0] <= '0;
			end
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_cell
		tlik_cordic_cell #(.Stage(i), .FracBits(FracBits), .W(W), .ZW(ZW)) u_cell (
			.clk(clk), .en(en),
			.x_in(xc[i]), .y_in(yc[i]), .z_in(zc[i]),
			.x_out(xc[i+1]), .y_out(yc[i+1]), .z_out(zc[i+1])
		);
		always_ff @(posedge clk) begin
			if (en) zero_c[i+1] <= zero_c[i];
		end
	end

	assign z = zero_c[N] ? '0 : zc[N];
endmodule

>>> src/two_link_arm_inverse_kinematics_top.sv
// Top level of the two-link arm inverse kinematics pipeline.
// One target transaction is accepted per cycle while the output is not stalled;
// each gives one angle transaction after passing through two
// 18-cell square-root chains and the CORDIC cell chain. The whole pipeline
// advances together and holds while a finished result waits at the output.
// The user writes link_length, base_height and gripper_pitch via the cfg channel
// (index 0, 1, 2) only while no transaction is in flight; the block does not check.
module two_link_arm_inverse_kinematics_top
	import tlik_pkg::*;
#(
	parameter int CORDIC_STAGES = 16,
	parameter int FRAC_BITS = 8
) (
	input  logic clk,
	input  logic arst_n,
	tlik_target_if.sink in_ch,
	tlik_angle_if.source out_ch,
	tlik_cfg_if.sink cfg
);
	localparam int SqW = 18;
	localparam int RadW = 2 * SqW;
	localparam int NStg = (CORDIC_STAGES > TableLen) ? TableLen : CORDIC_STAGES;
	localparam int Lat = 2 + SqW + SqW + 2 + 1 + NStg + 1;
	localparam int ZW = FRAC_BITS + 12;
	localparam int OW = ZW + 2;

	logic [13:0] link_length_q;
	logic signed [15:0] base_height_q;
	logic [7:0] gripper_pitch_q;
	logic [Lat-1:0] vld_q;
	logic en;

	// configuration registers
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_length_q <= 14'd3840;
			base_height_q <= 16'sd3328;
			gripper_pitch_q <= 8'd90;
		end else if (cfg.valid) begin
			unique case (reg_index_t'(cfg.index))
				REG_LINK_LENGTH: link_length_q <= cfg.data[13:0];
				REG_BASE_HEIGHT: base_height_q <= cfg.data;
				REG_GRIPPER_PITCH: gripper_pitch_q <= cfg.data[7:0];
				default: ;
			endcase
		end
	end

	// pipeline advances unless the output holds an untaken result
	assign en = !(out_ch.valid && !out_ch.ready);
	assign in_ch.ready = en;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (en) vld_q <= {vld_q[Lat-2:0], in_ch.valid};
	end
	assign out_ch.valid = vld_q[Lat-1];

	// stage 1: offset y
	logic signed [16:0] x_s1, y_s1;
	logic [14:0] two_l_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= 17'(in_ch.target_x);
			y_s1 <= 17'(in_ch.target_y) - 17'(base_height_q);
			two_l_s1 <= {link_length_q, 1'b0};
		end
	end

	// stage 2: squared distance
	logic signed [16:0] x_s2, y_s2;
	logic [14:0] two_l_s2;
	logic [RadW-1:0] rad_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			x_s2 <= x_s1; y_s2 <= y_s1; two_l_s2 <= two_l_s1;
			rad_s2 <= RadW'(34'(x_s1 * x_s1)) + RadW'(34'(y_s1 * y_s1));
		end
	end

	// first root chain; operands ride alongside
	logic [RadW-1:0] r1_rem [0:SqW];
	logic [SqW-1:0] r1_root [0:SqW];
	logic signed [16:0] xd [0:SqW];
	logic signed [16:0] yd [0:SqW];
	logic [14:0] tl [0:SqW];
	assign r1_rem[0] = rad_s2;
	assign r1_root[0] = '0;
	assign xd[0] = x_s2; assign yd[0] = y_s2; assign tl[0] = two_l_s2;
	for (genvar i = 0; i < SqW; i++) begin : g_sq1
		tlik_sqrt_cell #(.RadW(RadW), .ResW(SqW), .Step(i)) u_c (
			.clk(clk), .en(en), .rem_in(r1_rem[i]), .root_in(r1_root[i]),
			.rem_out(r1_rem[i+1]), .root_out(r1_root[i+1])
		);
		always_ff @(posedge clk) begin
			if (en) begin xd[i+1] <= xd[i]; yd[i+1] <= yd[i]; tl[i+1] <= tl[i]; end
		end
	end

	// clamp distance, form (2L)^2 - d^2
	logic [14:0] bound;
	logic [SqW-1:0] dcl;
	logic [14:0] d_s3;
	logic [RadW-1:0] hr_s3;
	logic signed [16:0] x_s3, y_s3;
	assign bound = (tl[SqW] >= 15'd3) ? tl[SqW] - 15'd3 : 15'd0;
	assign dcl = (r1_root[SqW] > SqW'(bound)) ? SqW'(bound) : r1_root[SqW];
	always_ff @(posedge clk) begin
		if (en) begin
			d_s3 <= dcl[14:0];
			x_s3 <= xd[SqW]; y_s3 <= yd[SqW];
			hr_s3 <= RadW'(30'(tl[SqW] * tl[SqW])) - RadW'(30'(dcl[14:0] * dcl[14:0]));
		end
	end

	// second root chain for the height h
	logic [RadW-1:0] r2_rem [0:SqW];
	logic [SqW-1:0] r2_root [0:SqW];
	logic [14:0] dd [0:SqW];
	logic signed [16:0] xe [0:SqW];
	logic signed [16:0] ye [0:SqW];
	assign r2_rem[0] = hr_s3;
	assign r2_root[0] = '0;
	assign dd[0] = d_s3; assign xe[0] = x_s3; assign ye[0] = y_s3;
	for (genvar i = 0; i < SqW; i++) begin : g_sq2
		tlik_sqrt_cell #(.RadW(RadW), .ResW(SqW), .Step(i)) u_c (
			.clk(clk), .en(en), .rem_in(r2_rem[i]), .root_in(r2_root[i]),
			.rem_out(r2_rem[i+1]), .root_out(r2_root[i+1])
		);
		always_ff @(posedge clk) begin
			if (en) begin dd[i+1] <= dd[i]; xe[i+1] <= xe[i]; ye[i+1] <= ye[i]; end
		end
	end

	// stage 4: register CORDIC operands
	logic signed [17:0] ax_s4, ay_s4, bx_s4, by_s4;
	always_ff @(posedge clk) begin
		if (en) begin
			ax_s4 <= 18'(xe[SqW]); ay_s4 <= 18'(ye[SqW]);
			bx_s4 <= 18'({1'b0, dd[SqW]}); by_s4 <= r2_root[SqW];
		end
	end

	logic signed [ZW-1:0] alpha, beta;
	tlik_cordic #(.Stages(CORDIC_STAGES), .FracBits(FRAC_BITS), .InW(18), .W(44), .ZW(ZW))
	u_alpha (.clk(clk), .en(en), .y(ay_s4), .x(ax_s4), .z(alpha));
	tlik_cordic #(.Stages(CORDIC_STAGES), .FracBits(FRAC_BITS), .InW(18), .W(44), .ZW(ZW))
	u_beta (.clk(clk), .en(en), .y(by_s4), .x(bx_s4), .z(beta));

	// pitch delayed to meet the angles
	logic [7:0] pitch_d [0:Lat-2];
	assign pitch_d[0] = gripper_pitch_q;
	for (genvar i = 0; i < Lat - 2; i++) begin : g_pd
		always_ff @(posedge clk) if (en) pitch_d[i+1] <= pitch_d[i];
	end

	// saturate to 0..180 and drop the fraction
	function automatic logic [7:0] to_deg(input logic signed [OW-1:0] v);
		logic signed [OW-1:0] top;
		logic [7:0] r;
		begin
			top = OW'(180) <<< FRAC_BITS;
			if (v < 0) r = 8'd0;
			else if (v > top) r = 8'd180;
			else r = 8'(v >>> FRAC_BITS);
			return r;
		end
	endfunction

	logic signed [OW-1:0] pv;
	assign pv = OW'({1'b0, pitch_d[Lat-2]}) <<< FRAC_BITS;
	always_ff @(posedge clk) begin
		if (en) begin
			out_ch.shoulder_angle <= to_deg(OW'(beta) + OW'(alpha));
			out_ch.elbow_angle <= to_deg(OW'(beta) <<< 1);
			out_ch.wrist_angle <= to_deg(OW'(beta) - OW'(alpha) + pv);
		end
	end
endmodule

>>> dv/two_link_arm_inverse_kinematics_top_test.sv
// Self-checking testbench for the two-link arm inverse kinematics pipeline.
module two_link_arm_inverse_kinematics_top_test;
	import tlik_pkg::*;

	localparam int Stages = 16;
	localparam int Frac = 8;
	localparam int Latency = 2 + 18 + 18 + 2 + Stages + 2;
	localparam int WatchLimit = 20000;
	localparam int NumRandom = 1030;

	typedef struct packed {
		logic [7:0] shoulder;
		logic [7:0] elbow;
		logic [7:0] wrist;
	} angles_t;

	// directed row: target, optional typed-in expectation
	typedef struct {
		logic signed [15:0] x;
		logic signed [15:0] y;
		bit typed;
		angles_t want;
	} target_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	tlik_target_if in_ch();
	tlik_angle_if out_ch();
	tlik_cfg_if cfg();

	two_link_arm_inverse_kinematics_top #(.CORDIC_STAGES(Stages), .FRAC_BITS(Frac)) DUT (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source), .cfg(cfg.sink)
	);

	// predictor copy of the registers
	logic [13:0] link_len;
	logic signed [15:0] base_h;
	logic [7:0] pitch_deg;

	angles_t angle_queue[$];
	int errors = 0;
	int angles_seen = 0;
	int targets_sent = 0;
	int idle_cycles = 0;
	bit stall_long = 1'b0;
	bit stim_done = 1'b0;

	initial begin
		forever #10 clk = ~clk;
	end

	// integer square root, floor
	function automatic longint unsigned root_floor(input longint unsigned n);
		longint unsigned res, bit_v;
		res = 0;
		bit_v = 64'd1 << 62;
		while (bit_v > n) bit_v >>= 2;
		while (bit_v != 0) begin
			if (n >= res + bit_v) begin
				n -= res + bit_v;
				res = (res >> 1) + bit_v;
			end else begin
				res >>= 1;
			end
			bit_v >>= 2;
		end
		return res;
	endfunction

	// own copy of the arctangent table, degrees * 2^16
	function automatic longint unsigned atan_deg16_tb(input int i);
		longint unsigned tbl[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
			58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7,
			4, 2, 1, 0};
		return tbl[i % 24];
	endfunction

	function automatic longint step_angle(input int i);
		longint unsigned t;
		t = atan_deg16_tb(i);
		return longint'((t + (64'd1 << (15 - Frac))) >> (16 - Frac));
	endfunction

	// vectoring-mode arctangent in degrees with Frac fraction bits
	function automatic longint vector_angle(input longint yi, input longint xi);
		longint x, y, z, t, xs, ys;
		if (xi == 0 && yi == 0) return 0;
		x = xi <<< 24;
		y = yi <<< 24;
		z = 0;
		if (x < 0) begin
			if (y >= 0) begin
				t = y; y = -x; x = t; z = 90 <<< Frac;
			end else begin
				t = -y; y = x; x = t; z = -(90 <<< Frac);
			end
		end
		for (int i = 0; i < Stages && i < 24; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x += ys; y -= xs; z += step_angle(i);
			end else begin
				x -= ys; y += xs; z -= step_angle(i);
			end
		end
		return z;
	endfunction

	function automatic logic [7:0] clamp_degree(input longint v);
		if (v < 0) v = 0;
		if (v > (180 <<< Frac)) v = 180 <<< Frac;
		return 8'(v >>> Frac);
	endfunction

	function automatic angles_t solve_arm(input logic signed [15:0] tx,
			input logic signed [15:0] ty);
		longint x, y, two_l, bound, d, h, alpha, beta, p;
		angles_t r;
		x = tx;
		y = longint'(ty) - longint'(base_h);
		two_l = 2 * longint'(link_len);
		bound = (two_l >= 3) ? two_l - 3 : 0;
		d = longint'(root_floor(longint'(x * x + y * y)));
		if (d > bound) d = bound;
		h = longint'(root_floor(longint'(two_l * two_l - d * d)));
		alpha = vector_angle(y, x);
		beta = vector_angle(h, d);
		p = longint'(pitch_deg) <<< Frac;
		r.shoulder = clamp_degree(beta + alpha);
		r.elbow = clamp_degree(2 * beta);
		r.wrist = clamp_degree(beta - alpha + p);
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		errors++;
		$display("MISMATCH %s: got %0d expected %0d (result %0d)", what, got, want, angles_seen);
	endtask

	// configuration write, only while idle
	task automatic write_reg(input reg_index_t idx, input logic [15:0] val);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= val;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		cfg.valid <= 1'b0;
		case (idx)
			REG_LINK_LENGTH: link_len = val[13:0];
			REG_BASE_HEIGHT: base_h = val;
			default: pitch_deg = val[7:0];
		endcase
		@(posedge clk);
	endtask

	task automatic drain();
		while (angle_queue.size() != 0) @(posedge clk);
		repeat (Latency + 4) @(posedge clk);
	endtask

	// send one target transaction, sender gaps in bursts
	int burst_left = 0;
	task automatic send_target(input logic signed [15:0] tx, input logic signed [15:0] ty);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				in_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 30);
		end
		burst_left--;
		in_ch.valid <= 1'b1;
		in_ch.target_x <= tx;
		in_ch.target_y <= ty;
		angle_queue.push_back(solve_arm(tx, ty));
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		targets_sent++;
	endtask

	// receiver: own stall pattern plus one long hold-off
	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (stall_long) out_ch.ready <= 1'b0;
			else if (angles_seen % 200 < 60) out_ch.ready <= 1'b1;
			else out_ch.ready <= ($urandom_range(0, 3) != 0);
		end
	end

	// result checker
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			angles_t want;
			angles_seen++;
			if (angle_queue.size() == 0) begin
				report_mismatch("unexpected angle transaction", out_ch.shoulder_angle, 0);
			end else begin
				want = angle_queue.pop_front();
				if (out_ch.shoulder_angle != want.shoulder)
					report_mismatch("shoulder", out_ch.shoulder_angle, want.shoulder);
				if (out_ch.elbow_angle != want.elbow)
					report_mismatch("elbow", out_ch.elbow_angle, want.elbow);
				if (out_ch.wrist_angle != want.wrist)
					report_mismatch("wrist", out_ch.wrist_angle, want.wrist);
			end
		end
	end

	// watchdog: cycles with no transaction
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
				(cfg.valid && cfg.ready) || stall_long)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WatchLimit) begin
			$display("Watchdog expired");
			$display("Test completed with failures");
			$finish;
		end
	end

	// long hold-off while the sender keeps offering
	initial begin
		wait (targets_sent == 300);
		stall_long = 1'b1;
		repeat (Latency * 3) @(posedge clk);
		stall_long = 1'b0;
	end

	function automatic logic signed [15:0] rand_coord(input int span);
		case ($urandom_range(0, 5))
			0: return 16'($urandom);
			default: return 16'($signed($urandom_range(0, 2 * span)) - span);
		endcase
	endfunction

	initial begin
		target_row_t rows[$];
		angles_t got_want;
		in_ch.valid = 1'b0;
		in_ch.target_x = '0;
		in_ch.target_y = '0;
		cfg.valid = 1'b0;
		cfg.index = REG_LINK_LENGTH;
		cfg.data = '0;
		link_len = 14'd3840;
		base_h = 16'sd3328;
		pitch_deg = 8'd90;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table; typed expectations where obvious
		rows.push_back('{16'sd0, 16'sd3328, 1'b0, '0}); // origin target
		rows.push_back('{-16'sh8000, 16'sd3328, 1'b1, '{8'd180, 8'd3, 8'd0}}); // far behind
		rows.push_back('{16'sh7FFF, 16'sh7FFF, 1'b0, '0});
		rows.push_back('{-16'sh8000, -16'sh8000, 1'b0, '0});
		rows.push_back('{-16'sh8000, 16'sh7FFF, 1'b0, '0});
		rows.push_back('{16'sh7FFF, -16'sh8000, 1'b0, '0});
		rows.push_back('{16'sd7680, 16'sd3328, 1'b0, '0});  // straight reach, clamped
		rows.push_back('{-16'sd2000, 16'sd3328, 1'b0, '0}); // negative x on axis
		rows.push_back('{-16'sd2000, 16'sd5000, 1'b0, '0});
		rows.push_back('{-16'sd2000, 16'sd1000, 1'b0, '0});
		rows.push_back('{16'sd0, 16'sd5000, 1'b0, '0});
		rows.push_back('{16'sd0, 16'sd1000, 1'b0, '0});
		rows.push_back('{16'sd3000, 16'sd6000, 1'b0, '0});
		rows.push_back('{16'sd1, 16'sd3329, 1'b0, '0});
		foreach (rows[i]) begin
			if (rows[i].typed) begin
				got_want = solve_arm(rows[i].x, rows[i].y);
				if (got_want != rows[i].want) report_mismatch("table row", i, 0);
			end
			send_target(rows[i].x, rows[i].y);
		end
		in_ch.valid <= 1'b0;
		drain();

		// extremes of registers
		write_reg(REG_LINK_LENGTH, 16'd0);       // zero link
		write_reg(REG_BASE_HEIGHT, 16'h8000);
		write_reg(REG_GRIPPER_PITCH, 8'd255);    // pitch above range
		send_target(16'sd0, 16'sd0);
		send_target(16'sh7FFF, -16'sd5);
		in_ch.valid <= 1'b0;
		drain();
		write_reg(REG_LINK_LENGTH, 16'd1);
		write_reg(REG_BASE_HEIGHT, 16'h7FFF);
		write_reg(REG_GRIPPER_PITCH, 8'd0);
		send_target(16'sd0, 16'sh7FFF);
		send_target(-16'sd3, -16'sd4);
		send_target(-16'sh8000, 16'sh7FFF);
		in_ch.valid <= 1'b0;
		drain();

		// random phases over several settings
		for (int ph = 0; ph < 5; ph++) begin
			int span;
			case (ph)
				0: begin
					write_reg(REG_LINK_LENGTH, 16'd3840);
					write_reg(REG_BASE_HEIGHT, 16'd3328);
					write_reg(REG_GRIPPER_PITCH, 8'd90);
				end
				1: begin
					write_reg(REG_LINK_LENGTH, 16'h3FFF);
					write_reg(REG_BASE_HEIGHT, 16'd0);
					write_reg(REG_GRIPPER_PITCH, 8'd180);
				end
				default: begin
					write_reg(REG_LINK_LENGTH, 16'($urandom_range(1, 16383)));
					write_reg(REG_BASE_HEIGHT, 16'($urandom));
					write_reg(REG_GRIPPER_PITCH, 16'($urandom_range(0, 255)));
				end
			endcase
			span = 2 * int'(link_len) + 64;
			if (span > 32767) span = 32767;
			for (int n = 0; n < NumRandom / 5; n++)
				send_target(rand_coord(span), 16'(rand_coord(span) + base_h));
			in_ch.valid <= 1'b0;
			drain();
		end

		$display("Sent %0d targets, checked %0d angle results over several register settings",
			targets_sent, angles_seen);
		if (errors == 0 && angle_queue.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
